/* src/prime_stream_filter_unit_assert.svh */
// ----------------------------------------------------------------------------
// prime_stream_filter_unit assertion macros
// Shared wrappers for the concurrent checks of the filter.
// ----------------------------------------------------------------------------
`ifndef PRIME_STREAM_FILTER_UNIT_ASSERT_SVH
`define PRIME_STREAM_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define PSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/psf_pkg.sv */
// ----------------------------------------------------------------------------
// psf_pkg
// Types and constants of the prime stream filter.
// ----------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

	localparam int VALUE_BITS    = 16;
	localparam int POS_BITS      = 16;
	localparam int DIV_BITS      = VALUE_BITS / 2 + 2;
	localparam int SQ_BITS       = VALUE_BITS + 2;
	localparam int CNT_BITS      = $clog2(VALUE_BITS + 1);
	localparam int FIRST_DIVISOR = 2;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  last_in_set;
	} item_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value_out;
		logic                  keep;
		logic [POS_BITS-1:0]   kept_position;
		logic                  end_of_set;
	} result_t;

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [DIV_BITS-1:0]   divisor;
	} rem_req_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_rsp_t;

endpackage

`default_nettype wire

/* src/prime_stream_filter_unit.sv */
// ----------------------------------------------------------------------------
// prime_stream_filter_unit
// Primality filter over sets of values, one result per item.
// ----------------------------------------------------------------------------
// Each item is tested by trial division with divisors d = 2, 3, ... while
// d*d <= value; each remainder comes from a bit-serial unit that takes one
// dividend bit per cycle. One item is in work at a time. Each divisor tried
// takes one pass through S_CHECK and S_DIV; up to 254 divisors are tried for
// a 16-bit prime, one for an even value of four or more, none for values
// below four. The finished result sits in an output register, so the next
// item is taken while it waits. kept_position counts primes within the set
// and clears after the item marked last_in_set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prime_stream_filter_unit_assert.svh"

module prime_stream_filter_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_stall,
	input  wire psf_pkg::item_t item,
	output logic                result_valid,
	input  wire                 result_stall,
	output psf_pkg::result_t    result
);
	import psf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CHECK = 4'b0010,
		S_DIV   = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  last_q;
	logic                  prime_q;
	logic [DIV_BITS-1:0]   d_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic [POS_BITS-1:0]   kept_count_q;
	logic                  out_valid_q;
	result_t               out_q;
	rem_req_t              req;
	rem_rsp_t              rsp;
	logic                  item_take;
	logic                  fin_load;
	logic                  too_small;
	logic                  past_root;

	assign item_stall = (state_q != S_IDLE);
	assign item_take  = item_valid && !item_stall;
	assign fin_load   = (state_q == S_FIN) && (!out_valid_q || !result_stall);
	assign too_small  = val_q < VALUE_BITS'(FIRST_DIVISOR);
	assign past_root  = sq_q > SQ_BITS'(val_q);

	assign req.start    = (state_q == S_CHECK) && !too_small && !past_root;
	assign req.dividend = val_q;
	assign req.divisor  = d_q;

	psf_rem_serial u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kept_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_take) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (too_small || past_root) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rsp.done) begin
						state_q <= rsp.zero ? S_FIN : S_CHECK;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (fin_load) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					kept_count_q <= '0;
				end else if (prime_q) begin
					kept_count_q <= kept_count_q + POS_BITS'(1);
				end
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			val_q  <= item.value;
			last_q <= item.last_in_set;
			d_q    <= DIV_BITS'(FIRST_DIVISOR);
			sq_q   <= SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
		end
		if (state_q == S_CHECK) begin
			if (too_small) begin
				prime_q <= 1'b0;
			end else if (past_root) begin
				prime_q <= 1'b1;
			end
		end
		if (state_q == S_DIV && rsp.done) begin
			if (rsp.zero) begin
				prime_q <= 1'b0;
			end else begin
				d_q  <= d_q + DIV_BITS'(1);
				sq_q <= sq_q + SQ_BITS'({d_q, 1'b1});
			end
		end
		if (fin_load) begin
			out_q.value_out     <= val_q;
			out_q.keep          <= prime_q;
			out_q.kept_position <= prime_q ? kept_count_q : '0;
			out_q.end_of_set    <= last_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`PSF_ASSERT_NEXT(a_take_to_check, clk, arst_n, item_take, state_q == S_CHECK, "item taken but test not started")
	`PSF_ASSERT_NOW(a_done_in_div, clk, arst_n, rsp.done, state_q == S_DIV, "remainder done outside division")
	`PSF_ASSERT_NOW(a_drop_pos_zero, clk, arst_n, out_valid_q && !out_q.keep, out_q.kept_position == '0, "dropped item with nonzero position")
	`PSF_ASSERT_NEXT(a_last_clears, clk, arst_n, fin_load && last_q, kept_count_q == '0, "count not cleared at end of set")

endmodule

`default_nettype wire

/* src/psf_rem_serial.sv */
// ----------------------------------------------------------------------------
// psf_rem_serial
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_rem_serial (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire psf_pkg::rem_req_t req,
	output psf_pkg::rem_rsp_t      rsp
);
	import psf_pkg::*;

	logic                  busy_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  done_q;
	logic                  zero_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [DIV_BITS-1:0]   div_q;
	logic [DIV_BITS:0]     trial;
	logic                  fits;
	logic [DIV_BITS-1:0]   rem_next;

	assign trial    = {rem_q, shift_q[VALUE_BITS-1]};
	assign fits     = trial >= {1'b0, div_q};
	assign rem_next = fits ? DIV_BITS'(trial - {1'b0, div_q}) : trial[DIV_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					zero_q <= (rem_next == '0);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			shift_q <= req.dividend;
			rem_q   <= '0;
			div_q   <= req.divisor;
		end else if (busy_q) begin
			shift_q <= shift_q << 1;
			rem_q   <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.zero = zero_q;

endmodule

`default_nettype wire
